/* rtl/core/azs_pkg.sv */
// Shared types, codes and constants of the alarm zone supervisor.
package azs_pkg;

  localparam int ZONES_DEFAULT = 8;

  localparam int CODE_W    = 8;
  localparam int ZONE_W    = 3;
  localparam int COUNT_W   = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OK_LOW     = 2'd0;
  localparam logic [1:0] REG_OK_HIGH    = 2'd1;
  localparam logic [1:0] REG_ALARM_LOW  = 2'd2;
  localparam logic [1:0] REG_ALARM_HIGH = 2'd3;

  // Bounds for the volt windows 4.05..4.6 V (OK) and 3..4.0 V (alarm), 51.2 codes per volt
  localparam logic [CODE_W-1:0] OK_LOW_RST     = 8'd208;
  localparam logic [CODE_W-1:0] OK_HIGH_RST    = 8'd235;
  localparam logic [CODE_W-1:0] ALARM_LOW_RST  = 8'd154;
  localparam logic [CODE_W-1:0] ALARM_HIGH_RST = 8'd204;

  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_OK       = 2'd1,
    ST_ALARM    = 2'd2,
    ST_SABOTAGE = 2'd3
  } azs_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_WRITE,
    S_COUNT,
    S_DONE
  } azs_state_e;

  // Compare steps of the shared unit
  localparam logic [1:0] STEP_OK_LOW     = 2'd0;
  localparam logic [1:0] STEP_OK_HIGH    = 2'd1;
  localparam logic [1:0] STEP_ALARM_LOW  = 2'd2;
  localparam logic [1:0] STEP_ALARM_HIGH = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] ok_low;
    logic [CODE_W-1:0] ok_high;
    logic [CODE_W-1:0] alarm_low;
    logic [CODE_W-1:0] alarm_high;
  } azs_bounds_t;

  typedef struct packed {
    logic        wr;
    azs_status_e wdata;
  } azs_store_ctl_t;

  typedef struct packed {
    logic [ZONE_W-1:0]  zone;
    azs_status_e        zone_status;
    logic [COUNT_W-1:0] ok_count;
    logic [COUNT_W-1:0] alarm_count;
    logic [COUNT_W-1:0] sabotage_count;
    logic               system_ok;
    logic               system_alarm;
    logic               system_sabotage;
  } azs_result_t;

endpackage

/* rtl/core/alarm_zone_supervisor.sv */
// Alarm zone supervisor top level: register port, sequencer and result register.
//
// Each sample on the input stream belongs to the next zone in round-robin order
// (zone 0 after reset). It is sorted as OK, alarm or sabotage against the window
// bounds in the four registers, stored as that zone's status, and answered with one
// result carrying the zone, its new status, the zone tallies and the system flags.
// No new sample is taken until the current item has handed its result to the output
// register: one comparator checks the four bounds in turn, the status is written,
// and the tally walks the status store one zone a cycle. A finished result waits in
// that register, so the next sample is taken while it is still pending. Zones read
// as unknown after reset and count in no tally.
module alarm_zone_supervisor import azs_pkg::*; #(
  parameter int ZONES = ZONES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o,
  // sample stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [7:0] sample
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // [2:0] zone, [4:3] zone_status,
                                                  // [8:5] ok_count, [12:9] alarm_count,
                                                  // [16:13] sabotage_count, [17] system_ok,
                                                  // [18] system_alarm, [19] system_sabotage
);

  azs_bounds_t     bounds_q;
  logic            cfg_wr;
  logic            res_valid, res_ready;
  azs_result_t     res;
  logic            out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [CODE_W-1:0] rd_val;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.ok_low     <= OK_LOW_RST;
      bounds_q.ok_high    <= OK_HIGH_RST;
      bounds_q.alarm_low  <= ALARM_LOW_RST;
      bounds_q.alarm_high <= ALARM_HIGH_RST;
    end else if (cfg_wr) begin
      unique case (paddr_i[3:2])
        REG_OK_LOW:     bounds_q.ok_low     <= pwdata_i[CODE_W-1:0];
        REG_OK_HIGH:    bounds_q.ok_high    <= pwdata_i[CODE_W-1:0];
        REG_ALARM_LOW:  bounds_q.alarm_low  <= pwdata_i[CODE_W-1:0];
        REG_ALARM_HIGH: bounds_q.alarm_high <= pwdata_i[CODE_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      REG_OK_LOW:     rd_val = bounds_q.ok_low;
      REG_OK_HIGH:    rd_val = bounds_q.ok_high;
      REG_ALARM_LOW:  rd_val = bounds_q.alarm_low;
      REG_ALARM_HIGH: rd_val = bounds_q.alarm_high;
      default:        rd_val = '0;
    endcase
  end

  assign prdata_o = APB_DATA_W'(rd_val);

  azs_seq #(.ZONES(ZONES)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bounds_i    (bounds_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .sample_i    (s_axis_tdata_i[CODE_W-1:0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Hand over when the result register is empty or being drained
  assign res_ready = ~out_valid_q | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {4'b0000, res.system_sabotage, res.system_alarm, res.system_ok,
                     res.sabotage_count, res.alarm_count, res.ok_count,
                     res.zone_status, res.zone};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* rtl/core/azs_cmp_unit.sv */
// Shared 8-bit magnitude comparator used for every window bound check.
module azs_cmp_unit import azs_pkg::*; (
  input  logic [CODE_W-1:0] a_i,
  input  logic [CODE_W-1:0] b_i,
  output logic              ge_o
);

  logic [CODE_W:0] diff;

  // Borrow out of a - b tells a < b
  assign diff = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = ~diff[CODE_W];

endmodule

/* rtl/core/azs_zone_store.sv */
// Per-zone status store with its round-robin write pointer.
module azs_zone_store import azs_pkg::*; #(
  parameter int ZONES = ZONES_DEFAULT,
  localparam int PTR_W = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  azs_store_ctl_t ctl_i,
  input  logic [PTR_W-1:0] rd_idx_i,
  output azs_status_e    rd_data_o,
  output logic [PTR_W-1:0] ptr_o
);

  azs_status_e      status_q [ZONES];
  logic [PTR_W-1:0] ptr_q, ptr_d;

  always_comb begin
    if (ptr_q == PTR_W'(ZONES - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < ZONES; i++) begin
        status_q[i] <= ST_UNKNOWN;
      end
    end else if (ctl_i.wr) begin
      status_q[ptr_q] <= ctl_i.wdata;
      ptr_q           <= ptr_d;
    end
  end

  assign rd_data_o = status_q[rd_idx_i];
  assign ptr_o     = ptr_q;

endmodule

/* rtl/core/azs_seq.sv */
// Sequencer: steps the shared comparator over the bounds, then walks the zone store.
module azs_seq import azs_pkg::*; #(
  parameter int ZONES = ZONES_DEFAULT,
  localparam int PTR_W = (ZONES > 1) ? $clog2(ZONES) : 1,
  localparam int CNT_W = $clog2(ZONES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  azs_bounds_t       bounds_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CODE_W-1:0] sample_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output azs_result_t       res_o
);

  localparam int SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int ZEXT_W = PTR_W + ZONE_W;

  azs_state_e        state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [3:0]        hit_q, hit_d;
  logic [CODE_W-1:0] sample_q, sample_d;
  azs_status_e       status_q, status_d;
  logic [PTR_W-1:0]  zone_q, zone_d;
  logic [PTR_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  ok_cnt_q, ok_cnt_d;
  logic [CNT_W-1:0]  al_cnt_q, al_cnt_d;
  logic [CNT_W-1:0]  sa_cnt_q, sa_cnt_d;
  logic              al_latch_q, al_latch_d;
  logic              sa_latch_q, sa_latch_d;

  logic [CODE_W-1:0] cmp_a, cmp_b;
  logic              cmp_ge;
  azs_store_ctl_t    store_ctl;
  azs_status_e       rd_status;
  logic [PTR_W-1:0]  ptr;
  logic              all_ok;
  logic              al_next, sa_next;
  logic [ZEXT_W-1:0] zone_ext;

  azs_cmp_unit u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .ge_o (cmp_ge)
  );

  azs_zone_store #(.ZONES(ZONES)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (store_ctl),
    .rd_idx_i  (idx_q),
    .rd_data_o (rd_status),
    .ptr_o     (ptr)
  );

  // Operand select for the shared comparator
  always_comb begin
    unique case (step_q)
      STEP_OK_LOW: begin
        cmp_a = sample_q;
        cmp_b = bounds_i.ok_low;
      end
      STEP_OK_HIGH: begin
        cmp_a = bounds_i.ok_high;
        cmp_b = sample_q;
      end
      STEP_ALARM_LOW: begin
        cmp_a = sample_q;
        cmp_b = bounds_i.alarm_low;
      end
      default: begin
        cmp_a = bounds_i.alarm_high;
        cmp_b = sample_q;
      end
    endcase
  end

  assign all_ok = (ok_cnt_q == CNT_W'(ZONES));

  // Clear sticky flags when all zones are OK, set them while any zone still reports
  assign al_next = (al_latch_q & ~all_ok) | (al_cnt_q != '0);
  assign sa_next = (sa_latch_q & ~all_ok) | (sa_cnt_q != '0);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    hit_d      = hit_q;
    sample_d   = sample_q;
    status_d   = status_q;
    zone_d     = zone_q;
    idx_d      = idx_q;
    ok_cnt_d   = ok_cnt_q;
    al_cnt_d   = al_cnt_q;
    sa_cnt_d   = sa_cnt_q;
    al_latch_d = al_latch_q;
    sa_latch_d = sa_latch_q;
    store_ctl  = '{wr: 1'b0, wdata: status_q};
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sample_d = sample_i;
          step_d   = STEP_OK_LOW;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        hit_d[step_q] = cmp_ge;
        step_d        = step_q + 1'b1;
        if (step_q == STEP_ALARM_HIGH) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        // OK window wins over an overlapping alarm window
        priority if (hit_q[STEP_OK_LOW] && hit_q[STEP_OK_HIGH]) begin
          status_d = ST_OK;
        end else if (hit_q[STEP_ALARM_LOW] && hit_q[STEP_ALARM_HIGH]) begin
          status_d = ST_ALARM;
        end else begin
          status_d = ST_SABOTAGE;
        end
        store_ctl = '{wr: 1'b1, wdata: status_d};
        zone_d    = ptr;
        idx_d     = '0;
        ok_cnt_d  = '0;
        al_cnt_d  = '0;
        sa_cnt_d  = '0;
        state_d   = S_COUNT;
      end
      S_COUNT: begin
        unique case (rd_status)
          ST_OK:       ok_cnt_d = ok_cnt_q + 1'b1;
          ST_ALARM:    al_cnt_d = al_cnt_q + 1'b1;
          ST_SABOTAGE: sa_cnt_d = sa_cnt_q + 1'b1;
          default:     ;
        endcase
        if (idx_q == PTR_W'(ZONES - 1)) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          al_latch_d = al_next;
          sa_latch_d = sa_next;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= STEP_OK_LOW;
      idx_q      <= '0;
      al_latch_q <= 1'b0;
      sa_latch_q <= 1'b0;
      ok_cnt_q   <= '0;
      al_cnt_q   <= '0;
      sa_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      idx_q      <= idx_d;
      al_latch_q <= al_latch_d;
      sa_latch_q <= sa_latch_d;
      ok_cnt_q   <= ok_cnt_d;
      al_cnt_q   <= al_cnt_d;
      sa_cnt_q   <= sa_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    sample_q <= sample_d;
    status_q <= status_d;
    zone_q   <= zone_d;
  end

  assign zone_ext = ZEXT_W'(zone_q);

  always_comb begin
    res_o.zone            = zone_ext[ZONE_W-1:0];
    res_o.zone_status     = status_q;
    res_o.ok_count        = (SAT_W'(ok_cnt_q) > SAT_W'(15)) ? 4'd15 : COUNT_W'(ok_cnt_q);
    res_o.alarm_count     = (SAT_W'(al_cnt_q) > SAT_W'(15)) ? 4'd15 : COUNT_W'(al_cnt_q);
    res_o.sabotage_count  = (SAT_W'(sa_cnt_q) > SAT_W'(15)) ? 4'd15 : COUNT_W'(sa_cnt_q);
    res_o.system_ok       = all_ok;
    res_o.system_alarm    = al_next;
    res_o.system_sabotage = sa_next;
  end

endmodule

/* rtl/core/azs_checker.sv */
// Port-level checks on the result stream of the alarm zone supervisor, with its bind.
module azs_checker import azs_pkg::*; #(
  parameter int ZONES = ZONES_DEFAULT
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_i,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_i
);

  logic [5:0] tally_sum;

  assign tally_sum = 6'(m_axis_tdata_i[8:5]) + 6'(m_axis_tdata_i[12:9])
                   + 6'(m_axis_tdata_i[16:13]);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  a_all_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[17] |->
      m_axis_tdata_i[12:9] == 4'd0 && m_axis_tdata_i[16:13] == 4'd0 &&
      !m_axis_tdata_i[18] && !m_axis_tdata_i[19])
    else $error("system OK with alarm or sabotage shown");

  a_alarm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[12:9] != 4'd0 |-> m_axis_tdata_i[18])
    else $error("alarm zone without alarm flag");

  a_sabotage_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[16:13] != 4'd0 |-> m_axis_tdata_i[19])
    else $error("sabotage zone without sabotage flag");

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> tally_sum <= 6'(ZONES))
    else $error("zone tallies exceed zone count");

endmodule

bind alarm_zone_supervisor azs_checker #(.ZONES(ZONES)) u_azs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Testbench of the alarm zone supervisor: sample stream, APB setup and result checks.
module testbench;
  import azs_pkg::*;

  localparam int NZ           = ZONES_DEFAULT;
  localparam int DRAIN_CYCLES = 2 * (NZ + 7);

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predictor state
  azs_bounds_t   bnd;
  azs_status_e   zone_state [NZ];
  int unsigned   zone_ptr;
  logic          alarm_seen;
  logic          sabotage_seen;
  azs_result_t   pending_reports [$];

  int   errors = 0;
  bit   idle_on = 1'b0;
  bit   long_hold = 1'b0;
  int   hold_len = 0;
  int   rx_stall = 0;
  event hold_go;

  alarm_zone_supervisor uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic void classify_sample(input logic [CODE_W-1:0] s);
    azs_result_t r;
    azs_status_e st;
    int n_ok = 0;
    int n_al = 0;
    int n_sa = 0;
    if (s >= bnd.ok_low && s <= bnd.ok_high) st = ST_OK;
    else if (s >= bnd.alarm_low && s <= bnd.alarm_high) st = ST_ALARM;
    else st = ST_SABOTAGE;
    zone_state[zone_ptr] = st;
    r.zone        = zone_ptr[ZONE_W-1:0];
    r.zone_status = st;
    zone_ptr = (zone_ptr == NZ - 1) ? 0 : zone_ptr + 1;
    foreach (zone_state[i]) begin
      case (zone_state[i])
        ST_OK:       n_ok++;
        ST_ALARM:    n_al++;
        ST_SABOTAGE: n_sa++;
        default: ;
      endcase
    end
    // all zones OK clears the sticky flags before they are set again
    if (n_ok == NZ) begin
      alarm_seen    = 1'b0;
      sabotage_seen = 1'b0;
    end
    if (n_sa > 0) sabotage_seen = 1'b1;
    if (n_al > 0) alarm_seen = 1'b1;
    r.ok_count        = COUNT_W'((n_ok > 15) ? 15 : n_ok);
    r.alarm_count     = COUNT_W'((n_al > 15) ? 15 : n_al);
    r.sabotage_count  = COUNT_W'((n_sa > 15) ? 15 : n_sa);
    r.system_ok       = (n_ok == NZ);
    r.system_alarm    = alarm_seen;
    r.system_sabotage = sabotage_seen;
    pending_reports.push_back(r);
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    azs_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing actual %h", $time, m_tdata);
      end else begin
        want = pending_reports.pop_front();
        check_field("zone", want.zone, m_tdata[2:0]);
        check_field("zone_status", want.zone_status, m_tdata[4:3]);
        check_field("ok_count", want.ok_count, m_tdata[8:5]);
        check_field("alarm_count", want.alarm_count, m_tdata[12:9]);
        check_field("sabotage_count", want.sabotage_count, m_tdata[16:13]);
        check_field("system_ok", want.system_ok, m_tdata[17]);
        check_field("system_alarm", want.system_alarm, m_tdata[18]);
        check_field("system_sabotage", want.system_sabotage, m_tdata[19]);
        check_field("padding", 0, m_tdata[23:20]);
      end
    end
  end

  // Result-side ready with random stall bursts
  always @(posedge clk_i) begin
    if (long_hold) begin
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_stall = $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Long receiver hold, counted on the falling edge
  initial begin
    forever begin
      @(hold_go);
      @(negedge clk_i) long_hold = 1'b1;
      repeat (hold_len) @(negedge clk_i);
      long_hold = 1'b0;
    end
  end

  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_sample(input logic [CODE_W-1:0] s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    classify_sample(s);
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one bound, then read it back
  task automatic program_bound(input logic [1:0] idx, input logic [CODE_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_OK_LOW:     bnd.ok_low     = v;
      REG_OK_HIGH:    bnd.ok_high    = v;
      REG_ALARM_LOW:  bnd.alarm_low  = v;
      REG_ALARM_HIGH: bnd.alarm_high = v;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(v)) begin
      errors++;
      $display("%0t: readback of register %0d expected %h actual %h", $time, idx,
               APB_DATA_W'(v), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_windows(input logic [7:0] okl, input logic [7:0] okh,
                                 input logic [7:0] all, input logic [7:0] alh);
    program_bound(REG_OK_LOW, okl);
    program_bound(REG_OK_HIGH, okh);
    program_bound(REG_ALARM_LOW, all);
    program_bound(REG_ALARM_HIGH, alh);
  endtask

  function automatic logic [7:0] pick_sample();
    int k;
    logic [7:0] b;
    k = $urandom_range(0, 9);
    if (k < 4 && bnd.ok_low <= bnd.ok_high)
      return 8'($urandom_range(bnd.ok_high, bnd.ok_low));
    if (k < 7 && bnd.alarm_low <= bnd.alarm_high)
      return 8'($urandom_range(bnd.alarm_high, bnd.alarm_low));
    if (k < 9) begin
      // land on or next to a window edge
      case ($urandom_range(0, 3))
        0:       b = bnd.ok_low;
        1:       b = bnd.ok_high;
        2:       b = bnd.alarm_low;
        default: b = bnd.alarm_high;
      endcase
      return b + 8'($urandom_range(0, 2)) - 8'd1;
    end
    return 8'($urandom);
  endfunction

  function automatic void pick_pair(output logic [7:0] lo, output logic [7:0] hi);
    logic [7:0] x;
    logic [7:0] y;
    x = 8'($urandom);
    y = 8'($urandom);
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    case ($urandom_range(0, 9))
      0: begin lo = hi; hi = (x < y) ? x : y; end
      1: lo = 8'd0;
      2: hi = 8'd255;
      default: ;
    endcase
  endfunction

  task automatic randomize_windows();
    logic [7:0] okl, okh, all, alh;
    if ($urandom_range(0, 4) == 0) begin
      program_windows(OK_LOW_RST, OK_HIGH_RST, ALARM_LOW_RST, ALARM_HIGH_RST);
    end else begin
      pick_pair(okl, okh);
      pick_pair(all, alh);
      program_windows(okl, okh, all, alh);
    end
  endtask

  // Reset bounds: window edges, the gap between windows, code extremes, a code just above the OK window, then all OK
  task automatic test_default_windows();
    logic [7:0] walk [8] = '{8'd208, 8'd235, 8'd154, 8'd204, 8'd206, 8'd0, 8'd255, 8'd236};
    foreach (walk[i]) send_sample(walk[i]);
    repeat (NZ) send_sample(8'd220);
    drain_results();
  endtask

  task automatic test_window_special_cases();
    // overlapping windows: OK wins
    program_windows(8'd100, 8'd200, 8'd50, 8'd150);
    send_sample(8'd120);
    send_sample(8'd60);
    send_sample(8'd201);
    drain_results();
    // empty OK window, alarm covers every code
    program_windows(8'd255, 8'd0, 8'd0, 8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    drain_results();
    // both windows empty
    program_bound(REG_ALARM_LOW, 8'd255);
    program_bound(REG_ALARM_HIGH, 8'd0);
    send_sample(8'd128);
    drain_results();
    program_windows(8'd0, 8'd255, 8'd0, 8'd0);
    send_sample(8'd77);
    drain_results();
  endtask

  // Hold results off so the block fills and stalls its input
  task automatic test_backpressure();
    program_windows(OK_LOW_RST, OK_HIGH_RST, ALARM_LOW_RST, ALARM_HIGH_RST);
    idle_on  = 1'b0;
    hold_len = 400;
    -> hold_go;
    repeat (40) send_sample(pick_sample());
    drain_results();
  endtask

  task automatic test_random_traffic(input int total);
    int sent = 0;
    int n;
    while (sent < total) begin
      randomize_windows();
      idle_on = (sent < total - 250) && ($urandom_range(0, 3) != 0);
      n = 0;
      while (n < 120 && sent < total) begin
        if ($urandom_range(0, 5) == 0 && bnd.ok_low <= bnd.ok_high) begin
          // full sweep of OK readings clears the sticky flags
          repeat (NZ) send_sample(8'($urandom_range(bnd.ok_high, bnd.ok_low)));
          n += NZ;
          sent += NZ;
        end else begin
          send_sample(pick_sample());
          n++;
          sent++;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    bnd = '{ok_low: OK_LOW_RST, ok_high: OK_HIGH_RST,
            alarm_low: ALARM_LOW_RST, alarm_high: ALARM_HIGH_RST};
    foreach (zone_state[i]) zone_state[i] = ST_UNKNOWN;
    zone_ptr      = 0;
    alarm_seen    = 1'b0;
    sabotage_seen = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_default_windows();
    test_window_special_cases();
    test_backpressure();
    test_random_traffic(1590);
    drain_results();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
